### rtl/running_statistics_accumulator_macros.svh
// Assertion macros for the running statistics accumulator.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef RUNNING_STATISTICS_ACCUMULATOR_MACROS_SVH
`define RUNNING_STATISTICS_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rsa_pkg.sv
// Shared types and constants of the running statistics accumulator.
// No dependencies; imported by every module of the block.
package rsa_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int DEFAULT_MAX_COUNT = 65535;
    localparam int COUNT_OUT_W       = 16;
    localparam int VAR_W             = 32;
    localparam int ROOT_W            = VAR_W / 2;
    localparam int IN_TDATA_W        = 16;
    localparam int IN_TUSER_W        = 3;
    localparam int OUT_TDATA_W       = 112;
    localparam int OUT_TUSER_W       = 2;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_FEW = 2'd1,
        STAT_SAT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MEAN,
        S_PROD,
        S_VLOAD,
        S_VAR,
        S_SQLOAD,
        S_ROOT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic acc;
        logic load_mean;
        logic div_step;
        logic mul;
        logic load_var;
        logic load_sqrt;
        logic sqrt_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic out_free;
    } t_stat;

endpackage

### rtl/rsa_div.sv
// Restoring divider, one quotient bit per step, shared by mean and variance.
// Depends on rsa_pkg only for the house import style.
module rsa_div
    import rsa_pkg::*;
#(
    parameter int DVD_W = 46,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot
);

    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {r_rem, r_quot[DVD_W-1]};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (i_step) begin
            if (fits) begin
                r_rem  <= DVS_W'(shifted - {1'b0, r_dvs});
                r_quot <= {r_quot[DVD_W-2:0], 1'b1};
            end else begin
                r_rem  <= shifted[DVS_W-1:0];
                r_quot <= {r_quot[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;

endmodule

### rtl/rsa_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per step.
// Depends on rsa_pkg for the variance and root widths.
module rsa_sqrt
    import rsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [VAR_W-1:0]  i_radicand,
    output logic [ROOT_W-1:0] o_root
);

    logic [VAR_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;

    assign rem_sh = {r_rem, r_rad[VAR_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_rad <= {r_rad[VAR_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= (ROOT_W+1)'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;

endmodule

### rtl/rsa_dp.sv
// Datapath: accumulators, shared divider, product stage, square root, output register.
// Depends on rsa_pkg, rsa_div and rsa_sqrt.
module rsa_dp
    import rsa_pkg::*;
#(
    parameter int MAX_COUNT = DEFAULT_MAX_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_has_sample,
    input  logic                       i_clear_first,
    input  logic                       i_out_ready,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output t_status                    o_status,
    output logic [COUNT_OUT_W-1:0]     o_count,
    output logic [SAMPLE_W-1:0]        o_min,
    output logic [SAMPLE_W-1:0]        o_max,
    output logic [SAMPLE_W-1:0]        o_mean,
    output logic [VAR_W-1:0]           o_var,
    output logic [ROOT_W-1:0]          o_root
);

    localparam int CW    = $clog2(MAX_COUNT + 1);
    localparam int SUM_W = SAMPLE_W + CW;
    localparam int SQ_W  = 2 * SAMPLE_W + CW;

    logic        [CW-1:0]       r_count, base_count, n_count;
    logic signed [SUM_W-1:0]    r_sum, base_sum, n_sum;
    logic        [SQ_W-1:0]     r_sumsq, base_sumsq, n_sumsq;
    logic signed [SAMPLE_W-1:0] r_min, base_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, base_max, n_max;
    logic signed [2*SAMPLE_W-1:0] sq;
    logic                       take;

    logic [SUM_W-1:0]    sum_mag;
    logic [SAMPLE_W-1:0] mean_mag;
    logic [SAMPLE_W-1:0] r_mean;
    logic [SQ_W-1:0]     r_prod;
    logic [SQ_W-1:0]     num;
    logic [VAR_W-1:0]    var_sat;
    logic [VAR_W-1:0]    r_var;
    logic [SQ_W-1:0]     div_dvd;
    logic [CW-1:0]       div_dvs;
    logic [SQ_W-1:0]     quot;
    logic [ROOT_W-1:0]   root;
    logic                few;

    logic                   r_valid;
    t_status                r_status;
    logic [COUNT_OUT_W-1:0] r_o_count;
    logic [SAMPLE_W-1:0]    r_o_min, r_o_max, r_o_mean;
    logic [VAR_W-1:0]       r_o_var;
    logic [ROOT_W-1:0]      r_o_root;

    // Accumulate: clear first, then add the sample unless the count is saturated.
    always_comb begin
        base_count = i_clear_first ? '0 : r_count;
        base_sum   = i_clear_first ? '0 : r_sum;
        base_sumsq = i_clear_first ? '0 : r_sumsq;
        base_min   = i_clear_first ? '0 : r_min;
        base_max   = i_clear_first ? '0 : r_max;
        sq         = (2*SAMPLE_W)'(i_sample * i_sample);
        take       = i_has_sample && (base_count < CW'(MAX_COUNT));
        n_count    = base_count;
        n_sum      = base_sum;
        n_sumsq    = base_sumsq;
        n_min      = base_min;
        n_max      = base_max;
        if (take) begin
            n_count = base_count + CW'(1);
            n_sum   = base_sum + SUM_W'(i_sample);
            n_sumsq = base_sumsq + SQ_W'(unsigned'(sq));
            if (base_count == '0) begin
                n_min = i_sample;
                n_max = i_sample;
            end else begin
                if (i_sample < base_min) n_min = i_sample;
                if (i_sample > base_max) n_max = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.acc) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign few      = (r_count < CW'(2));
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mean_mag = quot[SAMPLE_W-1:0];
    assign num      = (r_sumsq >= r_prod) ? (r_sumsq - r_prod) : '0;
    assign var_sat  = (|quot[SQ_W-1:VAR_W]) ? '1 : quot[VAR_W-1:0];

    always_comb begin
        if (i_cmd.load_var) begin
            div_dvd = num;
            div_dvs = r_count - CW'(1);
        end else begin
            div_dvd = SQ_W'(sum_mag);
            div_dvs = r_count;
        end
    end

    rsa_div #(
        .DVD_W (SQ_W),
        .DVS_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_mean || i_cmd.load_var),
        .i_step     (i_cmd.div_step),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (quot)
    );

    rsa_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_sqrt),
        .i_step     (i_cmd.sqrt_step),
        .i_radicand (var_sat),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_mean <= r_sum[SUM_W-1] ? SAMPLE_W'(-mean_mag) : mean_mag;
            r_prod <= SQ_W'(mean_mag * sum_mag);
        end
        if (i_cmd.load_sqrt) begin
            r_var <= var_sat;
        end
    end

    // Output register; the upstream side stays free while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_count <= COUNT_OUT_W'(r_count);
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            if (few) begin
                r_status <= STAT_FEW;
                r_o_mean <= '0;
                r_o_var  <= '0;
                r_o_root <= '0;
            end else begin
                r_status <= (r_count >= CW'(MAX_COUNT)) ? STAT_SAT : STAT_OK;
                r_o_mean <= r_mean;
                r_o_var  <= r_var;
                r_o_root <= root;
            end
        end
    end

    assign o_stat.few      = few;
    assign o_stat.out_free = !r_valid || i_out_ready;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_count  = r_o_count;
    assign o_min    = r_o_min;
    assign o_max    = r_o_max;
    assign o_mean   = r_o_mean;
    assign o_var    = r_o_var;
    assign o_root   = r_o_root;

endmodule

### rtl/rsa_ctrl.sv
// Controller: sequences accumulate, mean division, product, variance division,
// square root and output load. Depends on rsa_pkg.
module rsa_ctrl
    import rsa_pkg::*;
#(
    parameter int MAX_COUNT = DEFAULT_MAX_COUNT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_report,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    localparam int CW        = $clog2(MAX_COUNT + 1);
    localparam int DIV_STEPS = 2 * SAMPLE_W + CW;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_report) n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_mean = 1'b1;
                n_step  = '0;
                n_state = i_stat.few ? S_OUT : S_MEAN;
            end
            S_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.mul = 1'b1;
                n_state   = S_VLOAD;
            end
            S_VLOAD: begin
                o_cmd.load_var = 1'b1;
                n_step  = '0;
                n_state = S_VAR;
            end
            S_VAR: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = S_SQLOAD;
            end
            S_SQLOAD: begin
                o_cmd.load_sqrt = 1'b1;
                n_step  = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_W - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/running_statistics_accumulator.sv
// Running statistics accumulator. Each input item may clear the set, add one
// signed Q7.8 sample and ask for a report. Items without the report flag are
// taken back to back, so samples stream in at one per clock while no report
// is being worked on. A report item is followed by work before the next item
// is taken, done by one shared restoring divider that produces one quotient
// bit a cycle, used first for the mean and then for the variance, and by a
// square root unit that produces one root bit a cycle. A report over fewer
// than two samples skips that work and gives status 1 with zero mean, variance
// and standard deviation. The result sits in an output register, so the input
// side reopens while a finished result still waits to be taken; only a second
// report stalls on it. Once the count reaches MAX_COUNT further samples are
// dropped and reports carry status 2. Reset (synchronous, active low) clears
// all accumulators. Depends on rsa_pkg, rsa_ctrl, rsa_dp and the assertion
// macro header.
`include "running_statistics_accumulator_macros.svh"

module running_statistics_accumulator
    import rsa_pkg::*;
#(
    parameter int MAX_COUNT = DEFAULT_MAX_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] sample
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] has_sample, [1] clear_first, [2] report
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] sample_count, [31:16] minimum, [47:32] maximum,
    // [63:48] mean_value, [95:64] variance_value, [111:96] std_dev
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    t_cmd                   cmd;
    t_stat                  stat;
    t_status                status;
    logic [COUNT_OUT_W-1:0] count_o;
    logic [SAMPLE_W-1:0]    min_o, max_o, mean_o;
    logic [VAR_W-1:0]       var_o;
    logic [ROOT_W-1:0]      root_o;
    logic                   report_take;
    logic                   out_free;
    logic [4:0]             loads;

    // Sequence the work of one report item.
    rsa_ctrl #(
        .MAX_COUNT (MAX_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_report   (s_axis_tuser[2]),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Hold the accumulators and compute the statistics.
    rsa_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (signed'(s_axis_tdata[SAMPLE_W-1:0])),
        .i_has_sample  (s_axis_tuser[0]),
        .i_clear_first (s_axis_tuser[1]),
        .i_out_ready   (m_axis_tready),
        .o_stat        (stat),
        .o_valid       (m_axis_tvalid),
        .o_status      (status),
        .o_count       (count_o),
        .o_min         (min_o),
        .o_max         (max_o),
        .o_mean        (mean_o),
        .o_var         (var_o),
        .o_root        (root_o)
    );

    assign m_axis_tdata = {root_o, var_o, mean_o, max_o, min_o, count_o};
    assign m_axis_tuser = status;

    assign report_take = s_axis_tvalid && s_axis_tready && s_axis_tuser[2];
    assign out_free    = !m_axis_tvalid || m_axis_tready;
    assign loads       = {cmd.acc, cmd.load_mean, cmd.load_var, cmd.load_sqrt, cmd.load_out};

    // A report item always takes the block busy on the next cycle.
    `RSA_ASSERT_NEXT(a_busy_after_report, report_take, !s_axis_tready, "no stall after report")
    // Never overwrite a result that is still waiting downstream.
    `RSA_ASSERT_NOW(a_load_when_free, cmd.load_out, out_free, "result overwritten")
    // At most one of accumulate and the unit loads per cycle.
    `RSA_ASSERT_NOW(a_one_load, 1'b1, $onehot0(loads), "conflicting datapath loads")
    // Output valid rises only after a result load.
    `RSA_ASSERT_NOW(a_valid_from_load, $rose(m_axis_tvalid), $past(cmd.load_out), "stray valid")

endmodule

### bench/running_statistics_accumulator_tb.sv
// Self-checking bench for running_statistics_accumulator: streams samples, clears
// and report requests, predicts every report in-bench and checks it field by field.
// Depends on rsa_pkg and the accumulator RTL only.
module running_statistics_accumulator_tb;
    import rsa_pkg::*;

    // Keep the block at its default count limit.
    localparam int STAT_LIMIT     = DEFAULT_MAX_COUNT;
    // Rough cost of one report item: divider twice plus the square root pass.
    localparam int REPORT_CYCLES  = 120;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD_OFF  = 400;
    localparam int PHASE_ITEMS    = 350;
    localparam int LONG_RUN_ITEMS = 250;

    typedef longint unsigned t_u64;

    // Shapes of sample content used inside a well-formed run.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_CLUSTER,
        SPREAD_CONSTANT,
        SPREAD_EXTREME,
        SPREAD_SMALL
    } t_sample_spread;

    // One report as it leaves the block.
    typedef struct packed {
        t_status     status;
        logic [15:0] sample_count;
        logic [15:0] minimum;
        logic [15:0] maximum;
        logic [15:0] mean_value;
        logic [31:0] variance_value;
        logic [15:0] std_dev;
    } t_stats_report;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] sample
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [0] has_sample, [1] clear_first, [2] report
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] sample_count, [31:16] minimum, [47:32] maximum,
    // [63:48] mean_value, [95:64] variance_value, [111:96] std_dev
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [1:0] status
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Reports predicted but not yet seen on the output, oldest first.
    t_stats_report pending_reports[$];
    int error_count = 0;

    // Shadow of the accumulator state.
    int unsigned        acc_count  = 0;
    longint             acc_sum    = 0;
    t_u64               acc_sum_sq = 0;
    logic signed [15:0] acc_min    = '0;
    logic signed [15:0] acc_max    = '0;

    // Traffic shaping knobs.
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int idle_free_left  = 0;
    int hold_off_cycles = 0;
    int ready_run_left  = 0;
    int quiet_cycles    = 0;

    running_statistics_accumulator #(
        .MAX_COUNT(STAT_LIMIT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Floor square root, one root bit per pass from the top down.
    function automatic logic [15:0] floor_root(input logic [31:0] v);
        logic [15:0] root;
        logic [15:0] trial;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if (t_u64'(trial) * t_u64'(trial) <= t_u64'(v)) root = trial;
        end
        return root;
    endfunction

    // Advance the shadow accumulators by one item; return 1 and fill rep when the
    // item asks for a report.
    function automatic bit predict_statistics(input logic [15:0] raw, input bit add,
                                              input bit clr, input bit rpt,
                                              output t_stats_report rep);
        logic signed [15:0] val;
        longint             avg;
        t_u64               spread;
        t_u64               num;
        t_u64               var_full;
        val = $signed(raw);
        // Clear happens before this item's own sample.
        if (clr) begin
            acc_count  = 0;
            acc_sum    = 0;
            acc_sum_sq = 0;
            acc_min    = '0;
            acc_max    = '0;
        end
        // Drop the sample once the count has saturated.
        if (add && acc_count < STAT_LIMIT) begin
            acc_sum    += val;
            acc_sum_sq += t_u64'(longint'(val) * longint'(val));
            // The first sample of a set seeds both extremes.
            if (acc_count == 0 || val < acc_min) acc_min = val;
            if (acc_count == 0 || val > acc_max) acc_max = val;
            acc_count++;
        end
        if (!rpt) return 1'b0;
        rep.sample_count   = 16'(acc_count);
        rep.minimum        = acc_min;
        rep.maximum        = acc_max;
        rep.mean_value     = '0;
        rep.variance_value = '0;
        rep.std_dev        = '0;
        if (acc_count < 2) begin
            rep.status = STAT_FEW;
        end else begin
            // Signed division truncates toward zero; mean and sum share a sign.
            avg      = acc_sum / longint'(acc_count);
            spread   = t_u64'(avg * acc_sum);
            num      = (acc_sum_sq >= spread) ? acc_sum_sq - spread : 0;
            var_full = num / t_u64'(acc_count - 1);
            if (var_full > 64'h0000_0000_FFFF_FFFF) var_full = 64'h0000_0000_FFFF_FFFF;
            rep.status         = (acc_count >= STAT_LIMIT) ? STAT_SAT : STAT_OK;
            rep.mean_value     = avg[15:0];
            rep.variance_value = var_full[31:0];
            rep.std_dev        = floor_root(var_full[31:0]);
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_sample(input t_sample_spread spread,
                                                input logic [15:0] base);
        case (spread)
            SPREAD_FULL:     return 16'($urandom);
            SPREAD_CLUSTER:  return base + 16'($urandom_range(0, 31)) - 16'd16;
            SPREAD_CONSTANT: return base;
            SPREAD_EXTREME:  return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default:         return 16'($urandom_range(0, 1023)) - 16'd512;
        endcase
    endfunction

    task automatic check_field(input string name, input t_u64 want, input t_u64 got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Offer one item, possibly after a random idle gap, and hold it until taken.
    task automatic send_item(input logic [15:0] raw, input bit add, input bit clr,
                             input bit rpt);
        t_stats_report rep;
        if (idle_free_left > 0) begin
            idle_free_left--;
        end else if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            // Drop valid and scramble the bus while idle.
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            s_axis_tuser  <= 3'($urandom);
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= {rpt, clr, add};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_statistics(raw, add, clr, rpt, rep)) pending_reports.push_back(rep);
    endtask

    // Pause the sender until every predicted report has come out.
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // Extremes, empty and single-sample sets, clears with and without a sample,
    // truncation of a negative mean and a zero-variance set.
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);   // report on an empty set
        send_item(16'h1234, 1'b0, 1'b0, 1'b0);   // nothing to do
        send_item(16'h8000, 1'b1, 1'b0, 1'b1);   // first sample seeds min and max
        send_item(16'h7FFF, 1'b1, 1'b0, 1'b1);   // both extremes, mean truncates to 0
        send_item(16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);   // report without a sample
        send_item(16'h0000, 1'b0, 1'b1, 1'b1);   // clear alone
        send_item(16'hFFFD, 1'b1, 1'b1, 1'b1);   // clear then one sample
        send_item(16'hFFFC, 1'b1, 1'b0, 1'b1);   // negative mean, truncated toward zero
        send_item(16'h0000, 1'b0, 1'b1, 1'b0);
        send_item(16'h0500, 1'b1, 1'b0, 1'b0);
        send_item(16'h0500, 1'b1, 1'b0, 1'b1);   // zero variance
        send_item(16'h0001, 1'b1, 1'b0, 1'b0);
        send_item(16'h0002, 1'b1, 1'b0, 1'b0);
        send_item(16'h0180, 1'b1, 1'b0, 1'b1);
        send_item(16'h7FFF, 1'b1, 1'b1, 1'b0);
        send_item(16'h7FFF, 1'b1, 1'b0, 1'b1);   // largest mean
        send_item(16'h0000, 1'b1, 1'b0, 1'b1);
        send_item(16'hABCD, 1'b0, 1'b0, 1'b0);
        wait_for_reports();
    endtask

    // Long run of full-scale samples: large sums and sums of squares, with
    // reports along the way, then a restart with a clear.
    task automatic test_long_run();
        logic [15:0] raw;
        bit          rpt;
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        for (int n = 1; n <= LONG_RUN_ITEMS; n++) begin
            raw = (n % 4 == 3) ? 16'($urandom) : (n[0] ? 16'h7FFF : 16'h8000);
            rpt = (n <= 2) || (n >= LONG_RUN_ITEMS - 1) || (n % 64 == 0);
            send_item(raw, 1'b1, n == 1, rpt);
        end
        send_item(16'h8000, 1'b1, 1'b0, 1'b0);
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);
        send_item(16'h0042, 1'b1, 1'b1, 1'b1);       // restart with a fresh set
        wait_for_reports();
    endtask

    // Stall the result side long enough for a second report to back up the input.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        send_item(16'h0100, 1'b1, 1'b1, 1'b0);
        hold_off_cycles <= LONG_HOLD_OFF;
        for (int i = 0; i < 8; i++) begin
            send_item(16'($urandom), 1'b1, 1'b0, 1'b1);
            send_item(16'($urandom), 1'b1, 1'b0, 1'b0);
        end
        wait_for_reports();
    endtask

    // Mostly clear-samples-report runs with varied content; the rest is noise and
    // runs that skip the clear or the report.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int item_goal);
        int             counted;
        int             run_len;
        t_sample_spread spread;
        logic [15:0]    base;
        bit             keep_set;
        bit             rpt;
        logic [2:0]     flags;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        counted = 0;
        while (counted < item_goal) begin
            if ($urandom_range(9) == 0) idle_free_left = $urandom_range(10, 40);
            if ($urandom_range(99) < 80) begin
                run_len  = ($urandom_range(99) < 85) ? $urandom_range(1, 24)
                                                     : $urandom_range(25, 200);
                spread   = t_sample_spread'($urandom_range(4));
                base     = 16'($urandom);
                keep_set = ($urandom_range(9) == 0);
                for (int i = 0; i < run_len; i++) begin
                    rpt = (i == run_len - 1) ? ($urandom_range(9) != 0)
                                             : ($urandom_range(19) == 0);
                    send_item(pick_sample(spread, base), 1'b1, (i == 0) && !keep_set, rpt);
                    counted++;
                end
            end else begin
                flags = 3'($urandom);
                send_item(16'($urandom), flags[0], flags[1], flags[2]);
                if (flags != 3'b000) counted++;
            end
        end
        wait_for_reports();
    endtask

    // Result side: long hold-off on request, ready bursts, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_off_cycles != 0) begin
            m_axis_tready   <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (ready_run_left != 0) begin
            m_axis_tready  <= 1'b1;
            ready_run_left <= ready_run_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            if ($urandom_range(63) == 0) ready_run_left <= $urandom_range(10, 60);
        end
    end

    // Compare every accepted report against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_stats_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                error_count++;
                $display("%0t: unexpected report, expected none, got count 0x%0h",
                         $time, m_axis_tdata[15:0]);
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("sample_count", want.sample_count, m_axis_tdata[15:0]);
                check_field("minimum", want.minimum, m_axis_tdata[31:16]);
                check_field("maximum", want.maximum, m_axis_tdata[47:32]);
                check_field("mean_value", want.mean_value, m_axis_tdata[63:48]);
                check_field("variance_value", want.variance_value, m_axis_tdata[95:64]);
                check_field("std_dev", want.std_dev, m_axis_tdata[111:96]);
            end
        end
    end

    // Abort when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_long_run();
        test_output_backpressure();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(67, 0, PHASE_ITEMS);
        test_random_traffic(0, 67, PHASE_ITEMS);
        test_random_traffic(38, 38, PHASE_ITEMS);
        // Give a stray late report time to show up.
        repeat (2 * REPORT_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### running_statistics_accumulator.f
+incdir+rtl
rtl/rsa_pkg.sv
rtl/rsa_div.sv
rtl/rsa_sqrt.sv
rtl/rsa_dp.sv
rtl/rsa_ctrl.sv
rtl/running_statistics_accumulator.sv
bench/running_statistics_accumulator_tb.sv
